FILE: rtl/core/lvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector line generator package
// Shared widths and the command record that moves from the front end
// through the command queue to the back end.
// ----------------------------------------------------------------------------
package lvg_pkg;

   // Field widths of the request and response items.
   localparam int LVG_SLOT_W     = 4;
   localparam int LVG_COORD_W    = 16;
   localparam int LVG_SPL_W      = 7;
   localparam int LVG_REQ_DATA_W = 48;
   localparam int LVG_RSP_DATA_W = 32;

   // Request kinds carried on tuser.
   localparam logic LVG_MODE_STORE = 1'b0;
   localparam logic LVG_MODE_DRAW  = 1'b1;

   // Default run length after reset.
   localparam logic [LVG_SPL_W-1:0] LVG_SPL_RESET = 7'd32;

   // Number of quotient bits the serial divider produces.
   localparam int LVG_DIV_STEPS = LVG_COORD_W;
   localparam int LVG_DIV_CNT_W = $clog2(LVG_DIV_STEPS + 1);

   // One classified request as held in the command queue.
   typedef struct packed {
      logic                   is_draw;
      logic                   store_en;
      logic [LVG_SLOT_W-1:0]  store_slot;
      logic [LVG_COORD_W-1:0] x;
      logic [LVG_COORD_W-1:0] y;
      logic [LVG_SLOT_W-1:0]  from_slot;
      logic [LVG_SLOT_W-1:0]  to_slot;
      logic                   from_zero;
      logic                   to_zero;
   } lvg_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/lvg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector line generator front end
// Takes requests, unpacks the payload and classifies each one into a
// queue command, including the slot range checks.
// ----------------------------------------------------------------------------
module lvg_front #(
   parameter int VERTEX_SLOTS = 16
) (
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata: vertex_index, vertex_x, vertex_y, line_from, line_to (low bit up)
   input  wire logic [lvg_pkg::LVG_REQ_DATA_W-1:0]    req_tdata,
   // tuser: mode
   input  wire logic                                  req_tuser,
   input  wire logic                                  queue_full,
   output logic                                       push,
   output lvg_pkg::lvg_cmd_type                       cmd
);
   import lvg_pkg::*;

   logic [LVG_SLOT_W-1:0]  vertex_index;
   logic [LVG_COORD_W-1:0] vertex_x;
   logic [LVG_COORD_W-1:0] vertex_y;
   logic [LVG_SLOT_W-1:0]  line_from;
   logic [LVG_SLOT_W-1:0]  line_to;

   // Unpack the request payload.
   assign vertex_index = req_tdata[3:0];
   assign vertex_x     = req_tdata[19:4];
   assign vertex_y     = req_tdata[35:20];
   assign line_from    = req_tdata[39:36];
   assign line_to      = req_tdata[43:40];

   // A request is taken whenever the queue has room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classify: stores outside the table are dropped, reads outside it give zero.
   always_comb begin
      cmd.is_draw    = (req_tuser == LVG_MODE_DRAW);
      cmd.store_en   = (req_tuser == LVG_MODE_STORE) &&
                       (32'(vertex_index) < VERTEX_SLOTS);
      cmd.store_slot = vertex_index;
      cmd.x          = vertex_x;
      cmd.y          = vertex_y;
      cmd.from_slot  = line_from;
      cmd.to_slot    = line_to;
      cmd.from_zero  = !(32'(line_from) < VERTEX_SLOTS);
      cmd.to_zero    = !(32'(line_to) < VERTEX_SLOTS);
   end

endmodule
`default_nettype wire

FILE: rtl/core/lvg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector line generator command queue
// Two-entry queue that lets the front end keep taking requests while the
// back end is busy drawing.
// ----------------------------------------------------------------------------
module lvg_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lvg_pkg::lvg_cmd_type push_cmd,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output lvg_pkg::lvg_cmd_type      head_cmd
);
   import lvg_pkg::*;

   lvg_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/lvg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector line generator serial divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lvg_div #(
   parameter int NW = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [lvg_pkg::LVG_COORD_W-1:0] dividend,
   input  wire logic [NW-1:0]                  divisor,
   output logic                                done,
   output logic [lvg_pkg::LVG_COORD_W-1:0]     quotient,
   output logic [NW-1:0]                       remainder
);
   import lvg_pkg::*;

   logic [LVG_COORD_W-1:0]   quo_ff, quo_in;
   logic [NW-1:0]            rem_ff, rem_in;
   logic [NW-1:0]            div_ff, div_in;
   logic [LVG_DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [NW:0]              partial;
   logic                     fits;
   logic [NW:0]              diff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign partial = {rem_ff, quo_ff[LVG_COORD_W-1]};
   assign fits    = (partial >= {1'b0, div_ff});
   assign diff    = partial - {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = LVG_DIV_CNT_W'(LVG_DIV_STEPS);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[LVG_COORD_W-2:0], fits};
         rem_in  = fits ? diff[NW-1:0] : partial[NW-1:0];
         cnt_in  = cnt_ff - LVG_DIV_CNT_W'(1);
         done_in = (cnt_ff == LVG_DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lvg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector line generator back end
// Executes queued commands: writes the vertex table, reads two vertices,
// divides the axis deltas by the run length and steps along the segment
// into the response register, one sample per cycle unless the response stalls.
// ----------------------------------------------------------------------------
module lvg_back #(
   parameter int VERTEX_SLOTS     = 16,
   parameter int MAX_LINE_SAMPLES = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [lvg_pkg::LVG_SPL_W-1:0]    run_len,
   input  wire logic                             head_valid,
   input  wire lvg_pkg::lvg_cmd_type             head_cmd,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: x deflection, y deflection (low bit up)
   output logic [lvg_pkg::LVG_RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tlast
);
   import lvg_pkg::*;

   localparam int IDX_W = $clog2(VERTEX_SLOTS);
   localparam int NW    = $clog2(MAX_LINE_SAMPLES + 1);
   localparam int CW    = LVG_COORD_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   // Vertex tables.
   logic [CW-1:0] vx_mem_ff [VERTEX_SLOTS];
   logic [CW-1:0] vy_mem_ff [VERTEX_SLOTS];
   logic [CW-1:0] fx_rd_ff, fy_rd_ff, tx_rd_ff, ty_rd_ff;

   logic [1:0]    state_ff, state_in;
   logic          fz_ff, fz_in, tz_ff, tz_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] i_ff, i_in;

   // Per-axis stepping state.
   logic [CW-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic          negx_ff, negx_in, negy_ff, negy_in;
   logic [CW:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [NW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [CW:0]   qdx_ff, qdx_in, qdy_ff, qdy_in;
   logic [NW-1:0] rdx_ff, rdx_in, rdy_ff, rdy_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic          last_ff, last_in;

   logic [LVG_SLOT_W+IDX_W-1:0] wr_ext, from_ext, to_ext;
   logic [IDX_W-1:0]            wr_idx, from_idx, to_idx;
   logic                        store_pop, draw_pop, emit;
   logic [NW-1:0]               n_clamp;
   logic [CW-1:0]               fx_sel, fy_sel, tx_sel, ty_sel;
   logic [CW:0]                 dx, dy;
   logic [CW-1:0]               absx, absy;
   logic                        div_start;
   logic                        donex, doney;
   logic [CW-1:0]               quox, quoy;
   logic [NW-1:0]               remx, remy;
   logic [NW:0]                 rsumx, rsumy;
   logic                        wrapx, wrapy;
   logic [CW+1:0]               samp_x, samp_y;

   // Slot numbers to table indexes.
   assign wr_ext   = {{IDX_W{1'b0}}, head_cmd.store_slot};
   assign from_ext = {{IDX_W{1'b0}}, head_cmd.from_slot};
   assign to_ext   = {{IDX_W{1'b0}}, head_cmd.to_slot};
   assign wr_idx   = wr_ext[IDX_W-1:0];
   assign from_idx = from_ext[IDX_W-1:0];
   assign to_idx   = to_ext[IDX_W-1:0];

   assign pop       = (state_ff == ST_IDLE) && head_valid;
   assign store_pop = pop && !head_cmd.is_draw;
   assign draw_pop  = pop && head_cmd.is_draw;
   assign emit      = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_tready);

   // Table write on store commands, registered reads of both end points.
   always_ff @(posedge clock) begin
      if (store_pop && head_cmd.store_en) begin
         vx_mem_ff[wr_idx] <= head_cmd.x;
         vy_mem_ff[wr_idx] <= head_cmd.y;
      end
      fx_rd_ff <= vx_mem_ff[from_idx];
      fy_rd_ff <= vy_mem_ff[from_idx];
      tx_rd_ff <= vx_mem_ff[to_idx];
      ty_rd_ff <= vy_mem_ff[to_idx];
   end

   // Run length: zero counts as one, large values saturate.
   always_comb begin
      if (run_len == '0) begin
         n_clamp = NW'(1);
      end else if (32'(run_len) > MAX_LINE_SAMPLES) begin
         n_clamp = NW'(MAX_LINE_SAMPLES);
      end else begin
         n_clamp = NW'(32'(run_len));
      end
   end

   // End points and deltas; slots outside the table read as zero.
   assign fx_sel = fz_ff ? '0 : fx_rd_ff;
   assign fy_sel = fz_ff ? '0 : fy_rd_ff;
   assign tx_sel = tz_ff ? '0 : tx_rd_ff;
   assign ty_sel = tz_ff ? '0 : ty_rd_ff;
   assign dx     = {tx_sel[CW-1], tx_sel} - {fx_sel[CW-1], fx_sel};
   assign dy     = {ty_sel[CW-1], ty_sel} - {fy_sel[CW-1], fy_sel};
   assign absx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
   assign absy   = dy[CW] ? CW'(-dy) : dy[CW-1:0];

   assign div_start = (state_ff == ST_READ);

   lvg_div #(.NW(NW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (absx),
      .divisor   (n_ff),
      .done      (donex),
      .quotient  (quox),
      .remainder (remx)
   );

   lvg_div #(.NW(NW)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (absy),
      .divisor   (n_ff),
      .done      (doney),
      .quotient  (quoy),
      .remainder (remy)
   );

   // Incremental floor of d*i/n: add the per-step quotient and remainder,
   // carrying one when the remainder reaches n.
   assign rsumx = {1'b0, rx_ff} + {1'b0, rdx_ff};
   assign rsumy = {1'b0, ry_ff} + {1'b0, rdy_ff};
   assign wrapx = (rsumx >= {1'b0, n_ff});
   assign wrapy = (rsumy >= {1'b0, n_ff});

   // Floor becomes truncation toward zero for a negative product with a remainder.
   assign samp_x = {{2{fx_ff[CW-1]}}, fx_ff} + {qx_ff[CW], qx_ff} +
                   (CW+2)'(negx_ff && (rx_ff != '0));
   assign samp_y = {{2{fy_ff[CW-1]}}, fy_ff} + {qy_ff[CW], qy_ff} +
                   (CW+2)'(negy_ff && (ry_ff != '0));

   // Sequencer and datapath updates.
   always_comb begin
      state_in     = state_ff;
      fz_in        = fz_ff;
      tz_in        = tz_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      qdx_in       = qdx_ff;
      qdy_in       = qdy_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (draw_pop) begin
               fz_in    = head_cmd.from_zero;
               tz_in    = head_cmd.to_zero;
               n_in     = n_clamp;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            fx_in    = fx_sel;
            fy_in    = fy_sel;
            negx_in  = dx[CW];
            negy_in  = dy[CW];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (donex) begin
               // Turn the magnitude division into a floor division.
               if (!negx_in) begin
                  qdx_in = {1'b0, quox};
                  rdx_in = remx;
               end else if (remx == '0) begin
                  qdx_in = -{1'b0, quox};
                  rdx_in = '0;
               end else begin
                  qdx_in = ~{1'b0, quox};
                  rdx_in = n_ff - remx;
               end
               if (!negy_in) begin
                  qdy_in = {1'b0, quoy};
                  rdy_in = remy;
               end else if (remy == '0) begin
                  qdy_in = -{1'b0, quoy};
                  rdy_in = '0;
               end else begin
                  qdy_in = ~{1'b0, quoy};
                  rdy_in = n_ff - remy;
               end
               qx_in    = '0;
               qy_in    = '0;
               rx_in    = '0;
               ry_in    = '0;
               i_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               sx_in        = samp_x[CW-1:0];
               sy_in        = samp_y[CW-1:0];
               last_in      = (i_ff == n_ff - NW'(1));
               rx_in        = wrapx ? NW'(rsumx - {1'b0, n_ff}) : rsumx[NW-1:0];
               ry_in        = wrapy ? NW'(rsumy - {1'b0, n_ff}) : rsumy[NW-1:0];
               qx_in        = qx_ff + qdx_ff + (CW+1)'(wrapx);
               qy_in        = qy_ff + qdy_ff + (CW+1)'(wrapy);
               i_in         = i_ff + NW'(1);
               if (i_ff == n_ff - NW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fz_ff   <= fz_in;
      tz_ff   <= tz_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      qdx_ff  <= qdx_in;
      qdy_ff  <= qdy_in;
      rdx_ff  <= rdx_in;
      rdy_ff  <= rdy_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sy_ff, sx_ff};
   assign rsp_tlast  = last_ff;

   // Both axis dividers run in lockstep.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      donex == doney)
      else $error("axis dividers finished on different cycles");

   // The stepping remainders stay below the run length.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((rx_ff < n_ff) && (ry_ff < n_ff)))
      else $error("stepping remainder reached the run length");

   // The sample counter never passes the end of the run.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (i_ff < n_ff))
      else $error("sample counter ran past the run length");

   // The last sample of a run returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && (i_ff == n_ff - NW'(1))) |=> (state_ff == ST_IDLE) && rsp_valid_ff && last_ff)
      else $error("run did not end after its last sample");

endmodule
`default_nettype wire

FILE: rtl/core/xy_vector_line_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XY vector line generator
// Stores vertices in a small table and draws straight segments between
// them as a stream of interpolated XY samples for a vector display.
// ----------------------------------------------------------------------------
// A store request (tuser 0) writes one vertex as it is popped. A draw
// request (tuser 1) pops the command, reads both end points from the
// table, runs the bit-serial divisions of the two axis deltas by n, n
// being the run length from csr_data, sets up the step values and then
// emits one sample per cycle as long as the response side takes them.
// The two-entry command queue lets requests be taken while a line is
// still being drawn. Sample i is from + trunc((to - from) * i / n) on
// each axis and the last sample of the run carries tlast. A run length
// of zero acts as one and values above MAX_LINE_SAMPLES are clamped.
// Write csr_data only while the block is idle.
module xy_vector_line_generator #(
   parameter int VERTEX_SLOTS     = 16,
   parameter int MAX_LINE_SAMPLES = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: vertex_index, vertex_x, vertex_y, line_from, line_to (low bit up)
   input  wire logic [lvg_pkg::LVG_REQ_DATA_W-1:0]   req_tdata,
   // tuser: mode
   input  wire logic                                 req_tuser,
   // Response channel.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: x deflection, y deflection (low bit up)
   output logic [lvg_pkg::LVG_RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                      rsp_tlast,
   // Run length register write.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lvg_pkg::LVG_SPL_W-1:0]        csr_data
);
   import lvg_pkg::*;

   logic [LVG_SPL_W-1:0] spl_ff, spl_in;
   logic                 push;
   logic                 queue_full;
   lvg_cmd_type          push_cmd;
   logic                 pop;
   logic                 head_valid;
   lvg_cmd_type          head_cmd;

   // Run length register, always ready.
   assign csr_ready = 1'b1;
   assign spl_in    = csr_valid ? csr_data : spl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spl_ff <= LVG_SPL_RESET;
      end else begin
         spl_ff <= spl_in;
      end
   end

   lvg_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   lvg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lvg_back #(
      .VERTEX_SLOTS     (VERTEX_SLOTS),
      .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .run_len          (spl_ff),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule
`default_nettype wire
